@@ src/evpn_route_parser_unit_macros.svh @@
// Assertion macros shared by the EVPN route parser RTL.
`ifndef EVPN_ROUTE_PARSER_UNIT_MACROS_SVH
`define EVPN_ROUTE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EVPN_RP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define EVPN_RP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/evpn_rp_pkg.sv @@
// Types, constants and field capture functions for the EVPN route parser.
package evpn_rp_pkg;

  localparam logic [7:0] KIND_AD      = 8'd1;
  localparam logic [7:0] KIND_MAC_IP  = 8'd2;
  localparam logic [7:0] KIND_MCAST   = 8'd3;
  localparam logic [7:0] KIND_SEGMENT = 8'd4;

  localparam logic [7:0] RD_END        = 8'd8;
  localparam logic [7:0] ESI_TOP_END   = 8'd10;
  localparam logic [7:0] ESI_END       = 8'd18;
  localparam logic [7:0] MCAST_TAG_END = 8'd12;
  localparam logic [7:0] TAG_END       = 8'd22;
  localparam logic [7:0] AD_LEN        = 8'd25;
  localparam logic [7:0] MAC_START     = 8'd23;
  localparam logic [7:0] MAC_IP_IP_OFF = 8'd29;
  localparam logic [7:0] MCAST_IP_OFF  = 8'd12;
  localparam logic [7:0] SEG_IP_OFF    = 8'd18;
  localparam logic [7:0] LABEL_BYTES   = 8'd3;
  localparam logic [7:0] IP4_BITS      = 8'd32;
  localparam logic [7:0] IP6_BITS      = 8'd128;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OK_TWO_LBL = 3'd1,
    ST_SKIPPED    = 3'd2,
    ST_TRUNCATED  = 3'd3,
    ST_BAD_IP_LEN = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_TYPE = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_e;

  typedef struct packed {
    logic [63:0] rd;
    logic [15:0] esi_top;
    logic [63:0] esi_low;
    logic [31:0] tag;
    logic [47:0] mac;
    logic [7:0]  ip_len;
    logic [63:0] ip_hi;
    logic [63:0] ip_lo;
    logic [23:0] lbl_one;
    logic [23:0] lbl_two;
  } fields_t;

  typedef struct packed {
    logic [7:0] kind;
    fields_t    fields;
    status_e    status;
  } result_t;

  function automatic logic kind_known(logic [7:0] k);
    return (k >= KIND_AD) && (k <= KIND_SEGMENT);
  endfunction

  function automatic logic ip_len_good(logic [7:0] l);
    return (l == 8'd0) || (l == IP4_BITS) || (l == IP6_BITS);
  endfunction

  function automatic logic [7:0] ip_offset(logic [7:0] k);
    logic [7:0] off;
    if (k == KIND_MAC_IP) begin
      off = MAC_IP_IP_OFF;
    end else if (k == KIND_MCAST) begin
      off = MCAST_IP_OFF;
    end else begin
      off = SEG_IP_OFF;
    end
    return off;
  endfunction

  function automatic status_e finish_status(logic [7:0] k, logic [7:0] len,
                                            logic [7:0] ip_len);
    logic [7:0] off;
    logic [7:0] n;
    logic [7:0] need;
    status_e    st;
    off  = ip_offset(k);
    n    = ip_len >> 3;
    need = (k == KIND_MAC_IP) ? (off + n + 8'd4) : (off + n + 8'd1);
    if (!kind_known(k)) begin
      st = ST_SKIPPED;
    end else if (k == KIND_AD) begin
      st = (len < AD_LEN) ? ST_TRUNCATED : ST_OK;
    end else if (len <= off) begin
      st = ST_TRUNCATED;
    end else if (!ip_len_good(ip_len)) begin
      st = ST_BAD_IP_LEN;
    end else if (len < need) begin
      st = ST_TRUNCATED;
    end else if ((k == KIND_MAC_IP) && (len == need + LABEL_BYTES)) begin
      st = ST_OK_TWO_LBL;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

  function automatic fields_t capture(logic [7:0] k, logic [7:0] p, logic [7:0] len,
                                      fields_t f, logic [7:0] b);
    fields_t    r;
    logic [7:0] off;
    logic [7:0] n;
    logic [7:0] rel;
    logic [2:0] lane;
    r    = f;
    off  = ip_offset(k);
    n    = f.ip_len >> 3;
    rel  = p - off - 8'd1;
    lane = 3'd7 - rel[2:0];
    if (kind_known(k)) begin
      if (p < RD_END) begin
        r.rd = {f.rd[55:0], b};
      end else if ((k != KIND_MCAST) && (p < ESI_TOP_END)) begin
        r.esi_top = {f.esi_top[7:0], b};
      end else if ((k != KIND_MCAST) && (p < ESI_END)) begin
        r.esi_low = {f.esi_low[55:0], b};
      end else if ((k == KIND_MCAST) && (p < MCAST_TAG_END)) begin
        r.tag = {f.tag[23:0], b};
      end else if (((k == KIND_AD) || (k == KIND_MAC_IP)) && (p < TAG_END)) begin
        r.tag = {f.tag[23:0], b};
      end else if (k == KIND_AD) begin
        if (p < AD_LEN) begin
          r.lbl_one = {f.lbl_one[15:0], b};
        end
      end else if ((k == KIND_MAC_IP) && (p < MAC_IP_IP_OFF)) begin
        if (p >= MAC_START) begin
          r.mac = {f.mac[39:0], b};
        end
      end else if (p == off) begin
        r.ip_len = b;
      end else if ((p > off) && ip_len_good(f.ip_len)) begin
        if (rel < n) begin
          if (!rel[3]) begin
            r.ip_hi[{lane, 3'b000} +: 8] = f.ip_hi[{lane, 3'b000} +: 8] | b;
          end else begin
            r.ip_lo[{lane, 3'b000} +: 8] = f.ip_lo[{lane, 3'b000} +: 8] | b;
          end
        end else if (k == KIND_MAC_IP) begin
          if (p < off + n + 8'd4) begin
            r.lbl_one = {f.lbl_one[15:0], b};
          end else if ((p < off + n + 8'd7) && (len == off + n + 8'd7)) begin
            r.lbl_two = {f.lbl_two[15:0], b};
          end
        end
      end
    end
    return r;
  endfunction

endpackage

@@ src/evpn_rp_core.sv @@
// Parse phase, byte position and field shift registers of the EVPN route parser.
module evpn_rp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 beat_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 emit_o,
  output evpn_rp_pkg::result_t result_o
);
  import evpn_rp_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] kind_q, kind_d;
  fields_t    fld_q, fld_d;
  logic       emit;
  logic       use_fin;
  status_e    fin_status;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    len_d   = len_q;
    kind_d  = kind_q;
    fld_d   = fld_q;
    emit    = 1'b0;
    use_fin = 1'b0;
    if (beat_i) begin
      unique case (phase_q)
        PH_TYPE: begin
          fld_d  = '0;
          pos_d  = 8'd0;
          len_d  = 8'd0;
          kind_d = data_byte_i;
          if (last_byte_i) begin
            emit = 1'b1;
          end else begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          len_d = data_byte_i;
          pos_d = 8'd0;
          if (data_byte_i == 8'd0) begin
            emit    = 1'b1;
            use_fin = 1'b1;
          end else if (last_byte_i) begin
            emit = 1'b1;
          end else begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          fld_d = capture(kind_q, pos_q, len_q, fld_q, data_byte_i);
          pos_d = pos_q + 8'd1;
          if (pos_d == len_q) begin
            emit    = 1'b1;
            use_fin = 1'b1;
          end else if (last_byte_i) begin
            emit = 1'b1;
          end
        end
        default: begin
          phase_d = PH_TYPE;
        end
      endcase
      if (emit) begin
        phase_d = PH_TYPE;
      end
    end
  end

  assign fin_status = finish_status(kind_d, len_d, fld_d.ip_len);

  always_comb begin
    result_o.kind   = kind_d;
    result_o.fields = kind_known(kind_d) ? fld_d : '0;
    result_o.status = use_fin ? fin_status : ST_TRUNCATED;
  end

  assign emit_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      pos_q   <= 8'd0;
      len_q   <= 8'd0;
      kind_q  <= 8'd0;
      fld_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      kind_q  <= kind_d;
      fld_q   <= fld_d;
    end
  end

endmodule

@@ src/evpn_route_parser_unit.sv @@
// Top level of the EVPN route parser: handshake, result register and checks.

// The parser takes one EVPN route byte per beat, with last_byte_i marking the
// final byte of the attribute, and sustains one byte per clock cycle when
// not stalled. A route's result appears in the output register in the cycle
// after the beat that ends it. Input beats keep flowing while it waits; the
// input stalls only when the output register is full and the receiver stalls.
`include "evpn_route_parser_unit_macros.svh"

module evpn_route_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  route_kind_o,
  output logic [63:0] rd_value_o,
  output logic [15:0] esi_top_o,
  output logic [63:0] esi_low_o,
  output logic [31:0] ethernet_tag_o,
  output logic [47:0] mac_address_o,
  output logic [7:0]  ip_bits_o,
  output logic [63:0] ip_high_o,
  output logic [63:0] ip_low_o,
  output logic [23:0] label_one_o,
  output logic [23:0] label_two_o,
  output logic [2:0]  status_o
);
  import evpn_rp_pkg::*;

  logic    accept;
  logic    emit;
  result_t result;
  result_t out_q;
  logic    out_valid_q, out_valid_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  evpn_rp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .emit_o      (emit),
    .result_o    (result)
  );

  assign out_valid_d = (accept & emit) | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign route_kind_o   = out_q.kind;
  assign rd_value_o     = out_q.fields.rd;
  assign esi_top_o      = out_q.fields.esi_top;
  assign esi_low_o      = out_q.fields.esi_low;
  assign ethernet_tag_o = out_q.fields.tag;
  assign mac_address_o  = out_q.fields.mac;
  assign ip_bits_o      = out_q.fields.ip_len;
  assign ip_high_o      = out_q.fields.ip_hi;
  assign ip_low_o       = out_q.fields.ip_lo;
  assign label_one_o    = out_q.fields.lbl_one;
  assign label_two_o    = out_q.fields.lbl_two;
  assign status_o       = 3'(out_q.status);

  `EVPN_RP_ASSERT_NOW(a_stall_needs_result, in_stall_o, out_valid_o, "Input stalled with no result held.")
  `EVPN_RP_ASSERT_NEXT(a_emit_shows_result, accept && emit, out_valid_o, "Finished route did not reach the output.")
  `EVPN_RP_ASSERT_NOW(a_skip_fields_zero, out_valid_o && (status_o == 3'(ST_SKIPPED)), (rd_value_o == 64'd0) && (ip_bits_o == 8'd0) && (label_one_o == 24'd0), "Skipped route carries field data.")
  `EVPN_RP_ASSERT_NOW(a_two_labels_mac_ip, out_valid_o && (status_o == 3'(ST_OK_TWO_LBL)), route_kind_o == KIND_MAC_IP, "Two-label status on a route that is not MAC/IP.")

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the EVPN route parser: directed and random routes against a predictor.
`timescale 1ns / 1ps

module testbench;
  import evpn_rp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MIN_BYTES = 1300;
  localparam int MIN_ROUTES = 37;
  localparam int DRAIN_CYCLES = 20;
  localparam int N_DIRECTED = 25;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum int {FILL_ZERO, FILL_ONES, FILL_COUNT, FILL_RANDOM} fill_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    idle_mode_e mode;
    bit         typed;
    result_t    typed_res;
  } beat_t;

  typedef struct {
    logic [7:0] kind;
    int         len;
    logic [7:0] ip_len;
    fill_e      fill;
    int         cut;
    bit         last;
    bit         typed;
    status_e    typed_st;
  } route_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  route_kind_o;
  logic [63:0] rd_value_o;
  logic [15:0] esi_top_o;
  logic [63:0] esi_low_o;
  logic [31:0] ethernet_tag_o;
  logic [47:0] mac_address_o;
  logic [7:0]  ip_bits_o;
  logic [63:0] ip_high_o;
  logic [63:0] ip_low_o;
  logic [23:0] label_one_o;
  logic [23:0] label_two_o;
  logic [2:0]  status_o;

  beat_t      stim_beats[$];
  result_t    expected_routes[$];
  beat_t      cur_beat;
  idle_mode_e cur_mode = IDLE_NONE;
  route_row_t directed_rows [N_DIRECTED];
  string      field_names [12] = '{"route_kind", "rd_value", "esi_top", "esi_low",
                                   "ethernet_tag", "mac_address", "ip_bits", "ip_high",
                                   "ip_low", "label_one", "label_two", "status"};
  int         byte_count = 0;
  int         route_count = 0;
  int         fail_count = 0;
  int         cycle_count = 0;

  phase_e     pr_phase = PH_TYPE;
  int         pr_pos = 0;
  int         pr_len = 0;
  logic [7:0] pr_kind = 8'd0;
  fields_t    pr_f = '0;

  evpn_route_parser_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .route_kind_o  (route_kind_o),
    .rd_value_o    (rd_value_o),
    .esi_top_o     (esi_top_o),
    .esi_low_o     (esi_low_o),
    .ethernet_tag_o(ethernet_tag_o),
    .mac_address_o (mac_address_o),
    .ip_bits_o     (ip_bits_o),
    .ip_high_o     (ip_high_o),
    .ip_low_o      (ip_low_o),
    .label_one_o   (label_one_o),
    .label_two_o   (label_two_o),
    .status_o      (status_o)
  );

  function automatic bit known_kind(logic [7:0] k);
    return (k >= KIND_AD) && (k <= KIND_SEGMENT);
  endfunction

  function automatic bit ip_ok(logic [7:0] l);
    return (l == 8'd0) || (l == IP4_BITS) || (l == IP6_BITS);
  endfunction

  function automatic int ip_pos(logic [7:0] k);
    int pos;
    case (k)
      KIND_MAC_IP:  pos = int'(MAC_IP_IP_OFF);
      KIND_MCAST:   pos = int'(MCAST_IP_OFF);
      KIND_SEGMENT: pos = int'(SEG_IP_OFF);
      default:      pos = -1;
    endcase
    return pos;
  endfunction

  function automatic status_e route_verdict();
    int off;
    int n;
    int need;
    off = ip_pos(pr_kind);
    n = pr_f.ip_len / 8;
    need = off + n + ((pr_kind == KIND_MAC_IP) ? 4 : 1);
    if (!known_kind(pr_kind)) begin
      return ST_SKIPPED;
    end
    if (pr_kind == KIND_AD) begin
      return (pr_len < AD_LEN) ? ST_TRUNCATED : ST_OK;
    end
    if (pr_len <= off) begin
      return ST_TRUNCATED;
    end
    if (!ip_ok(pr_f.ip_len)) begin
      return ST_BAD_IP_LEN;
    end
    if (pr_len < need) begin
      return ST_TRUNCATED;
    end
    if ((pr_kind == KIND_MAC_IP) && (pr_len == need + 3)) begin
      return ST_OK_TWO_LBL;
    end
    return ST_OK;
  endfunction

  function automatic result_t route_result(status_e st);
    result_t r;
    r.kind = pr_kind;
    r.fields = known_kind(pr_kind) ? pr_f : '0;
    r.status = st;
    return r;
  endfunction

  task automatic shift_in_body_byte(input logic [7:0] b);
    int p;
    int off;
    int n;
    int rel;
    p = pr_pos;
    off = ip_pos(pr_kind);
    n = pr_f.ip_len / 8;
    rel = p - off - 1;
    if (known_kind(pr_kind)) begin
      if (p < RD_END) begin
        pr_f.rd = {pr_f.rd[55:0], b};
      end else if ((pr_kind != KIND_MCAST) && (p < ESI_TOP_END)) begin
        pr_f.esi_top = {pr_f.esi_top[7:0], b};
      end else if ((pr_kind != KIND_MCAST) && (p < ESI_END)) begin
        pr_f.esi_low = {pr_f.esi_low[55:0], b};
      end else if ((pr_kind == KIND_MCAST) && (p < MCAST_TAG_END)) begin
        pr_f.tag = {pr_f.tag[23:0], b};
      end else if (((pr_kind == KIND_AD) || (pr_kind == KIND_MAC_IP)) && (p < TAG_END)) begin
        pr_f.tag = {pr_f.tag[23:0], b};
      end else if (pr_kind == KIND_AD) begin
        if (p < AD_LEN) begin
          pr_f.lbl_one = {pr_f.lbl_one[15:0], b};
        end
      end else if ((pr_kind == KIND_MAC_IP) && (p < MAC_IP_IP_OFF)) begin
        if (p >= MAC_START) begin
          pr_f.mac = {pr_f.mac[39:0], b};
        end
      end else if (p == off) begin
        pr_f.ip_len = b;
      end else if ((p > off) && ip_ok(pr_f.ip_len)) begin
        if (rel < n) begin
          if (rel < 8) begin
            pr_f.ip_hi[8*(7-rel) +: 8] = pr_f.ip_hi[8*(7-rel) +: 8] | b;
          end else begin
            pr_f.ip_lo[8*(15-rel) +: 8] = pr_f.ip_lo[8*(15-rel) +: 8] | b;
          end
        end else if (pr_kind == KIND_MAC_IP) begin
          if (p < off + n + 4) begin
            pr_f.lbl_one = {pr_f.lbl_one[15:0], b};
          end else if ((p < off + n + 7) && (pr_len == off + n + 7)) begin
            pr_f.lbl_two = {pr_f.lbl_two[15:0], b};
          end
        end
      end
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lst,
                            output bit done, output status_e st);
    done = 1'b0;
    st = ST_OK;
    case (pr_phase)
      PH_LEN: begin
        pr_len = int'(b);
        pr_pos = 0;
        if (b == 8'd0) begin
          done = 1'b1;
          st = route_verdict();
        end else if (lst) begin
          done = 1'b1;
          st = ST_TRUNCATED;
        end else begin
          pr_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        shift_in_body_byte(b);
        pr_pos = (pr_pos + 1) & 255;
        if (pr_pos == pr_len) begin
          done = 1'b1;
          st = route_verdict();
        end else if (lst) begin
          done = 1'b1;
          st = ST_TRUNCATED;
        end
      end
      default: begin
        pr_f = '0;
        pr_pos = 0;
        pr_len = 0;
        pr_kind = b;
        if (lst) begin
          done = 1'b1;
          st = ST_TRUNCATED;
        end else begin
          pr_phase = PH_LEN;
        end
      end
    endcase
    if (done) begin
      pr_phase = PH_TYPE;
    end
  endtask

  task automatic add_route(input logic [7:0] kind, input int len, input logic [7:0] ip_len,
                           input fill_e fill, input int cut, input bit last,
                           input idle_mode_e mode, input bit typed, input status_e typed_st);
    int    total;
    int    ipos;
    beat_t bt;
    total = (cut > 0) ? cut : len + 2;
    ipos = ip_pos(kind);
    for (int i = 0; i < total; i++) begin
      if (i == 0) begin
        bt.data = kind;
      end else if (i == 1) begin
        bt.data = len[7:0];
      end else if (i - 2 == ipos) begin
        bt.data = ip_len;
      end else begin
        case (fill)
          FILL_ZERO:  bt.data = 8'h00;
          FILL_ONES:  bt.data = 8'hFF;
          FILL_COUNT: bt.data = 8'(i - 1);
          default:    bt.data = 8'($urandom_range(255));
        endcase
      end
      bt.last = (i == total - 1) && ((cut > 0) || last);
      bt.mode = mode;
      bt.typed = typed && (i == total - 1);
      bt.typed_res.kind = kind;
      bt.typed_res.fields = '0;
      bt.typed_res.status = typed_st;
      stim_beats.push_back(bt);
    end
    byte_count += total;
    route_count++;
  endtask

  function automatic logic [63:0] word_of(result_t r, int i);
    logic [63:0] w;
    case (i)
      0:       w = 64'(r.kind);
      1:       w = r.fields.rd;
      2:       w = 64'(r.fields.esi_top);
      3:       w = r.fields.esi_low;
      4:       w = 64'(r.fields.tag);
      5:       w = 64'(r.fields.mac);
      6:       w = 64'(r.fields.ip_len);
      7:       w = r.fields.ip_hi;
      8:       w = r.fields.ip_lo;
      9:       w = 64'(r.fields.lbl_one);
      10:      w = 64'(r.fields.lbl_two);
      default: w = 64'(r.status);
    endcase
    return w;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Byte sender and predictor: a beat is predicted at the edge where it is accepted.
  always @(posedge clk_i) begin : send_bytes
    bit      taken;
    bit      done;
    status_e st;
    int      idle_pct;
    if (rst_ni) begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        parse_byte(cur_beat.data, cur_beat.last, done, st);
        if (done) begin
          expected_routes.push_back(cur_beat.typed ? cur_beat.typed_res : route_result(st));
        end
      end
      if (!in_valid_i || taken) begin
        idle_pct = 0;
        if (stim_beats.size() > 0) begin
          idle_pct = (stim_beats[0].mode == IDLE_SEND) ? 79 :
                     (stim_beats[0].mode == IDLE_BOTH) ? 32 : 0;
        end
        if ((stim_beats.size() > 0) && ($urandom_range(99) >= idle_pct)) begin
          cur_beat = stim_beats.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= cur_beat.data;
          last_byte_i <= cur_beat.last;
          cur_mode <= cur_beat.mode;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_routes
    result_t     got;
    result_t     want;
    logic [63:0] gw;
    logic [63:0] ww;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < ((cur_mode == IDLE_RECV) ? 79 :
                                            (cur_mode == IDLE_BOTH) ? 32 : 0));
      if (out_valid_o && !out_stall_i) begin
        got.kind = route_kind_o;
        got.fields.rd = rd_value_o;
        got.fields.esi_top = esi_top_o;
        got.fields.esi_low = esi_low_o;
        got.fields.tag = ethernet_tag_o;
        got.fields.mac = mac_address_o;
        got.fields.ip_len = ip_bits_o;
        got.fields.ip_hi = ip_high_o;
        got.fields.ip_lo = ip_low_o;
        got.fields.lbl_one = label_one_o;
        got.fields.lbl_two = label_two_o;
        got.status = status_e'(status_o);
        if (expected_routes.size() == 0) begin
          if (fail_count < 10) begin
            $display("Unexpected route result: kind %h status %0d", route_kind_o, status_o);
          end
          fail_count++;
        end else begin
          want = expected_routes.pop_front();
          for (int i = 0; i < 12; i++) begin
            gw = word_of(got, i);
            ww = word_of(want, i);
            if (gw !== ww) begin
              if (fail_count < 10) begin
                $display("Mismatch in %s: expected %h, got %h", field_names[i], ww, gw);
              end
              fail_count++;
            end
          end
        end
      end
    end
  end

  initial begin : run_stimulus
    logic [7:0] kind;
    logic [7:0] ip_len;
    int         need;
    int         len;
    int         cut;
    int         pick;
    int         idx;
    fill_e      fill;
    directed_rows = '{
      '{8'd1,         0,   8'd0,   FILL_ZERO,   1,  1'b0, 1'b1, ST_TRUNCATED},
      '{8'd0,         0,   8'd0,   FILL_ZERO,   0,  1'b0, 1'b1, ST_SKIPPED},
      '{8'd255,       5,   8'd0,   FILL_ONES,   0,  1'b0, 1'b1, ST_SKIPPED},
      '{KIND_AD,      25,  8'd0,   FILL_COUNT,  0,  1'b0, 1'b0, ST_OK},
      '{KIND_AD,      30,  8'd0,   FILL_ONES,   0,  1'b0, 1'b0, ST_OK},
      '{KIND_AD,      24,  8'd0,   FILL_RANDOM, 0,  1'b0, 1'b0, ST_OK},
      '{KIND_AD,      0,   8'd0,   FILL_ZERO,   0,  1'b0, 1'b1, ST_TRUNCATED},
      '{KIND_MAC_IP,  33,  8'd0,   FILL_ONES,   0,  1'b0, 1'b0, ST_OK},
      '{KIND_MAC_IP,  37,  8'd32,  FILL_COUNT,  0,  1'b0, 1'b0, ST_OK},
      '{KIND_MAC_IP,  52,  8'd128, FILL_COUNT,  0,  1'b0, 1'b0, ST_OK},
      '{KIND_MAC_IP,  40,  8'd32,  FILL_ONES,   0,  1'b0, 1'b0, ST_OK},
      '{KIND_MAC_IP,  38,  8'd32,  FILL_RANDOM, 0,  1'b0, 1'b0, ST_OK},
      '{KIND_MAC_IP,  40,  8'd24,  FILL_ONES,   0,  1'b0, 1'b0, ST_OK},
      '{KIND_MAC_IP,  29,  8'd0,   FILL_RANDOM, 0,  1'b0, 1'b0, ST_OK},
      '{KIND_MAC_IP,  48,  8'd128, FILL_RANDOM, 0,  1'b0, 1'b0, ST_OK},
      '{KIND_MAC_IP,  200, 8'd0,   FILL_ZERO,   2,  1'b0, 1'b0, ST_OK},
      '{KIND_MCAST,   17,  8'd32,  FILL_ONES,   0,  1'b0, 1'b0, ST_OK},
      '{KIND_MCAST,   29,  8'd128, FILL_COUNT,  0,  1'b0, 1'b0, ST_OK},
      '{KIND_MCAST,   20,  8'd255, FILL_RANDOM, 0,  1'b0, 1'b0, ST_OK},
      '{KIND_MCAST,   255, 8'd32,  FILL_ONES,   0,  1'b0, 1'b0, ST_OK},
      '{KIND_SEGMENT, 19,  8'd0,   FILL_ZERO,   0,  1'b0, 1'b0, ST_OK},
      '{KIND_SEGMENT, 35,  8'd128, FILL_ONES,   0,  1'b0, 1'b0, ST_OK},
      '{KIND_SEGMENT, 35,  8'd128, FILL_COUNT,  22, 1'b0, 1'b0, ST_OK},
      '{KIND_SEGMENT, 0,   8'd0,   FILL_ZERO,   0,  1'b1, 1'b1, ST_TRUNCATED},
      '{8'd0,         0,   8'd0,   FILL_ZERO,   0,  1'b1, 1'b1, ST_SKIPPED}
    };
    for (int r = 0; r < N_DIRECTED; r++) begin
      add_route(directed_rows[r].kind, directed_rows[r].len, directed_rows[r].ip_len,
                directed_rows[r].fill, directed_rows[r].cut, directed_rows[r].last,
                IDLE_NONE, directed_rows[r].typed, directed_rows[r].typed_st);
    end
    idx = 0;
    while ((byte_count < MIN_BYTES) || (route_count < MIN_ROUTES)) begin
      kind = ($urandom_range(99) < 80) ? 8'($urandom_range(4, 1)) : 8'($urandom_range(255));
      pick = $urandom_range(9);
      ip_len = (pick < 3) ? 8'd0 : (pick < 5) ? IP4_BITS : (pick < 8) ? IP6_BITS :
               8'($urandom_range(255));
      case (kind)
        KIND_AD:      need = int'(AD_LEN);
        KIND_MAC_IP:  need = MAC_IP_IP_OFF + ip_len / 8 + 4;
        KIND_MCAST:   need = MCAST_IP_OFF + ip_len / 8 + 1;
        KIND_SEGMENT: need = SEG_IP_OFF + ip_len / 8 + 1;
        default:      need = $urandom_range(20);
      endcase
      pick = $urandom_range(99);
      len = (pick < 45) ? need : (pick < 65) ? need + 3 : (pick < 75) ? need + $urandom_range(5) :
            (pick < 90) ? $urandom_range(need) : $urandom_range(255);
      if (len > 255) begin
        len = 255;
      end
      cut = ($urandom_range(99) < 10) ? $urandom_range(len + 1, 1) : 0;
      pick = $urandom_range(19);
      fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : (pick == 2) ? FILL_COUNT :
             FILL_RANDOM;
      add_route(kind, len, ip_len, fill, cut, $urandom_range(99) < 25,
                idle_mode_e'((idx / 4) % 3 + 1), 1'b0, ST_OK);
      idx++;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while ((stim_beats.size() != 0) || in_valid_i) @(posedge clk_i);
    while (expected_routes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/evpn_rp_pkg.sv
src/evpn_rp_core.sv
src/evpn_route_parser_unit.sv
test/testbench.sv
